// File: sv/mma_pkg.sv
package mma_pkg;

    localparam int MAX_DIM    = 16;
    localparam int ELEM_WIDTH = 16;
    localparam int C_WIDTH    = 48;
    localparam int C_FRAC     = 16;

    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int KIND_W    = 3;
    localparam int POS_W     = 4;

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CELLS  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [KIND_W-1:0] REQ_WR_A = KIND_W'(0);
    localparam logic [KIND_W-1:0] REQ_WR_B = KIND_W'(1);
    localparam logic [KIND_W-1:0] REQ_WR_C = KIND_W'(2);
    localparam logic [KIND_W-1:0] REQ_RUN  = KIND_W'(3);
    localparam logic [KIND_W-1:0] REQ_READ = KIND_W'(4);

    localparam logic [CFG_IDX_W-1:0] CFG_DIM_M = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_N = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_K = CFG_IDX_W'(2);

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(16);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_MUL,
        ST_ACC,
        ST_READ
    } t_state;

    typedef struct packed {
        logic                  wr_a;
        logic                  wr_b;
        logic [ADDR_W-1:0]     addr;
        logic [ELEM_WIDTH-1:0] data;
    } t_ab_wr;

    typedef struct packed {
        logic [C_WIDTH-1:0] value;
        logic               mark;
    } t_c_entry;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_c_entry          entry;
    } t_c_wr;

    function automatic logic [ADDR_W-1:0] cell_addr(input int unsigned row,
                                                     input int unsigned col);
        return ADDR_W'(row * MAX_DIM + col);
    endfunction

endpackage

// File: sv/matrix_multiply_accumulate.sv
// channel   direction  handshake                 payload
// cfg       in         i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
// request   in         i_in_valid/o_in_ready     i_req_type, i_row_index, i_col_index,
//                                                i_elem_value
// response  out        o_out_valid/i_out_ready   o_resp_kind, o_read_value, o_sat_flag
//
// Writes and unknown kinds answer in the cycle after the beat; reads first pass
// through ST_READ. A run steps through ST_RD, ST_MUL and ST_ACC for each product:
// one read, multiply and write-back pass through the C memory and the single multiplier.
// One request is in flight at a time; a new beat is taken once the response
// register is free or being drained. Reset clears C at once via per-entry
// valid bits; no clearing pass is needed. Config beats are always taken.
module matrix_multiply_accumulate import mma_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [KIND_W-1:0]    i_req_type,
    input  logic [POS_W-1:0]     i_row_index,
    input  logic [POS_W-1:0]     i_col_index,
    input  logic signed [C_WIDTH-1:0] i_elem_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [KIND_W-1:0]    o_resp_kind,
    output logic signed [C_WIDTH-1:0] o_read_value,
    output logic                 o_sat_flag
);

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_dim_m, r_dim_n, r_dim_k;
    logic [IDX_W-1:0]  r_i, n_i, r_l, n_l, r_j, n_j;
    logic              r_any, n_any;
    logic              r_rd_inside, n_rd_inside;
    logic              r_out_valid;
    logic [KIND_W-1:0] r_resp_kind;
    logic [C_WIDTH-1:0] r_read_value;
    logic              r_sat_flag;

    logic              in_acc;
    logic              in_inside;
    logic [ADDR_W-1:0] in_addr;
    logic [ADDR_W-1:0] run_c_addr;
    logic [DIM_W-1:0]  eff_m, eff_n, eff_k;
    logic              dims_zero;
    logic              last_i, last_l, last_j;

    t_ab_wr            ab_wr;
    t_c_wr             c_wr;
    logic              ab_rd_en;
    logic              c_rd_en;
    logic [ADDR_W-1:0] c_rd_addr;
    logic              prod_en;
    logic [ELEM_WIDTH-1:0] a_data, b_data;
    t_c_entry          c_rd;
    t_c_entry          mac_sum;
    logic              mac_sat;

    logic              load_out;
    logic [KIND_W-1:0] out_kind;
    logic [C_WIDTH-1:0] out_value;
    logic              out_flag;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
        return (32'(d) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(d);
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;

    assign in_inside  = (32'(i_row_index) < MAX_DIM) && (32'(i_col_index) < MAX_DIM);
    assign in_addr    = cell_addr(32'(i_row_index), 32'(i_col_index));
    assign run_c_addr = cell_addr(32'(r_i), 32'(r_j));

    assign eff_m     = clamp_dim(r_dim_m);
    assign eff_n     = clamp_dim(r_dim_n);
    assign eff_k     = clamp_dim(r_dim_k);
    assign dims_zero = (eff_m == '0) || (eff_n == '0) || (eff_k == '0);
    assign last_i    = DIM_W'(r_i) == eff_m - DIM_W'(1);
    assign last_l    = DIM_W'(r_l) == eff_k - DIM_W'(1);
    assign last_j    = DIM_W'(r_j) == eff_n - DIM_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_m <= DIM_RESET;
            r_dim_n <= DIM_RESET;
            r_dim_k <= DIM_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DIM_M: r_dim_m <= i_cfg_data;
                CFG_DIM_N: r_dim_n <= i_cfg_data;
                CFG_DIM_K: r_dim_k <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_l         <= n_l;
        r_j         <= n_j;
        r_any       <= n_any;
        r_rd_inside <= n_rd_inside;
    end

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_l         = r_l;
        n_j         = r_j;
        n_any       = r_any;
        n_rd_inside = r_rd_inside;
        ab_wr       = '0;
        c_wr        = '0;
        ab_rd_en    = 1'b0;
        c_rd_en     = 1'b0;
        c_rd_addr   = run_c_addr;
        prod_en     = 1'b0;
        load_out    = 1'b0;
        out_kind    = i_req_type;
        out_value   = '0;
        out_flag    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                c_rd_addr  = in_addr;
                ab_wr.addr = in_addr;
                ab_wr.data = i_elem_value[ELEM_WIDTH-1:0];
                if (in_acc) begin
                    case (i_req_type)
                        REQ_WR_A: begin
                            ab_wr.wr_a = in_inside;
                            load_out   = 1'b1;
                        end
                        REQ_WR_B: begin
                            ab_wr.wr_b = in_inside;
                            load_out   = 1'b1;
                        end
                        REQ_WR_C: begin
                            c_wr.en          = in_inside;
                            c_wr.addr        = in_addr;
                            c_wr.entry.value = i_elem_value;
                            c_wr.entry.mark  = 1'b0;
                            load_out         = 1'b1;
                        end
                        REQ_RUN: begin
                            n_i   = '0;
                            n_l   = '0;
                            n_j   = '0;
                            n_any = 1'b0;
                            if (dims_zero) begin
                                load_out = 1'b1;
                            end else begin
                                n_state = ST_RD;
                            end
                        end
                        REQ_READ: begin
                            c_rd_en     = 1'b1;
                            n_rd_inside = in_inside;
                            n_state     = ST_READ;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                load_out  = 1'b1;
                out_kind  = REQ_READ;
                out_value = r_rd_inside ? c_rd.value : '0;
                out_flag  = r_rd_inside && c_rd.mark;
                n_state   = ST_IDLE;
            end
            ST_RD: begin
                ab_rd_en = 1'b1;
                c_rd_en  = 1'b1;
                n_state  = ST_MUL;
            end
            ST_MUL: begin
                prod_en = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                c_wr.en    = 1'b1;
                c_wr.addr  = run_c_addr;
                c_wr.entry = mac_sum;
                n_any      = r_any | mac_sat;
                n_state    = ST_RD;
                // walk order: row innermost, then inner dimension, then column
                if (!last_i) begin
                    n_i = r_i + IDX_W'(1);
                end else begin
                    n_i = '0;
                    if (!last_l) begin
                        n_l = r_l + IDX_W'(1);
                    end else begin
                        n_l = '0;
                        if (!last_j) begin
                            n_j = r_j + IDX_W'(1);
                        end else begin
                            load_out = 1'b1;
                            out_kind = REQ_RUN;
                            out_flag = r_any | mac_sat;
                            n_state  = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_resp_kind  <= out_kind;
            r_read_value <= out_value;
            r_sat_flag   <= out_flag;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_resp_kind  = r_resp_kind;
    assign o_read_value = $signed(r_read_value);
    assign o_sat_flag   = r_sat_flag;

    mma_ab_store u_ab_store (
        .i_clk    (i_clk),
        .i_wr     (ab_wr),
        .i_rd_en  (ab_rd_en),
        .i_a_addr (cell_addr(32'(r_i), 32'(r_l))),
        .i_b_addr (cell_addr(32'(r_l), 32'(r_j))),
        .o_a_data (a_data),
        .o_b_data (b_data)
    );

    mma_c_store u_c_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (c_wr),
        .i_rd_en   (c_rd_en),
        .i_rd_addr (c_rd_addr),
        .o_rd      (c_rd)
    );

    mma_mac u_mac (
        .i_clk     (i_clk),
        .i_prod_en (prod_en),
        .i_a       (a_data),
        .i_b       (b_data),
        .i_c       (c_rd),
        .o_sum     (mac_sum),
        .o_sat     (mac_sat)
    );

    a_write_answers_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type != REQ_RUN && i_req_type != REQ_READ) |=> o_out_valid)
        else $error("write beat not answered in the next cycle");

    a_read_answers_in_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == REQ_READ) |-> ##2 (o_out_valid && o_resp_kind == REQ_READ))
        else $error("read beat not answered two cycles later");

    a_plain_resp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_resp_kind != REQ_RUN && o_resp_kind != REQ_READ)
        |-> (!o_sat_flag && o_read_value == '0))
        else $error("non-read response carries data or flag");

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD || r_state == ST_MUL || r_state == ST_ACC) |-> !in_acc)
        else $error("request taken while a run is in progress");

endmodule

// File: sv/mma_ab_store.sv
module mma_ab_store import mma_pkg::*; (
    input  logic                  i_clk,
    input  t_ab_wr                i_wr,
    input  logic                  i_rd_en,
    input  logic [ADDR_W-1:0]     i_a_addr,
    input  logic [ADDR_W-1:0]     i_b_addr,
    output logic [ELEM_WIDTH-1:0] o_a_data,
    output logic [ELEM_WIDTH-1:0] o_b_data
);

    logic [ELEM_WIDTH-1:0] r_a_mem [CELLS];
    logic [ELEM_WIDTH-1:0] r_b_mem [CELLS];
    logic [ELEM_WIDTH-1:0] r_a_q;
    logic [ELEM_WIDTH-1:0] r_b_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_a) begin
            r_a_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_a_q <= r_a_mem[i_a_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_b) begin
            r_b_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_b_q <= r_b_mem[i_b_addr];
        end
    end

    assign o_a_data = r_a_q;
    assign o_b_data = r_b_q;

endmodule

// File: sv/mma_c_store.sv
module mma_c_store import mma_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_c_wr             i_wr,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_c_entry          o_rd
);

    t_c_entry         r_mem [CELLS];
    logic [CELLS-1:0] r_vld;
    t_c_entry         r_q;
    logic             r_q_vld;

    // entries never written since reset read as zero with a clear mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
        if (i_rd_en) begin
            r_q     <= r_mem[i_rd_addr];
            r_q_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd = r_q_vld ? r_q : '0;

endmodule

// File: sv/mma_mac.sv
module mma_mac import mma_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_prod_en,
    input  logic [ELEM_WIDTH-1:0] i_a,
    input  logic [ELEM_WIDTH-1:0] i_b,
    input  t_c_entry              i_c,
    output t_c_entry              o_sum,
    output logic                  o_sat
);

    localparam int SHR = (ELEM_WIDTH > C_FRAC) ? ELEM_WIDTH - C_FRAC : 0;
    localparam int SHL = (ELEM_WIDTH < C_FRAC) ? C_FRAC - ELEM_WIDTH : 0;

    logic signed [2*ELEM_WIDTH-1:0] r_prod;
    logic signed [63:0]             prod_ext;
    logic signed [63:0]             prod_al;
    logic        [C_WIDTH:0]        sum;

    always_ff @(posedge i_clk) begin
        if (i_prod_en) begin
            r_prod <= $signed(i_a) * $signed(i_b);
        end
    end

    always_comb begin
        prod_ext = 64'(r_prod);
        // bring the product to 16 fractional bits; arithmetic shift floors
        prod_al  = (prod_ext <<< SHL) >>> SHR;
        sum      = {i_c.value[C_WIDTH-1], i_c.value} + (C_WIDTH + 1)'(prod_al);
        o_sat    = sum[C_WIDTH] != sum[C_WIDTH-1];
        if (o_sat) begin
            o_sum.value = sum[C_WIDTH] ? {1'b1, {(C_WIDTH-1){1'b0}}}
                                       : {1'b0, {(C_WIDTH-1){1'b1}}};
        end else begin
            o_sum.value = sum[C_WIDTH-1:0];
        end
        o_sum.mark = i_c.mark | o_sat;
    end

endmodule

// File: dv/tb_matrix_multiply_accumulate.sv
`timescale 1ns / 100ps

module tb_matrix_multiply_accumulate;
    import mma_pkg::*;

    // request kinds the block does not decode; they must be echoed untouched
    localparam logic [KIND_W-1:0] REQ_RSVD_LO = KIND_W'(5);
    localparam logic [KIND_W-1:0] REQ_RSVD_HI = KIND_W'(7);

    localparam longint C_MAX = (longint'(1) <<< (C_WIDTH - 1)) - 1;
    localparam longint C_MIN = -C_MAX - 1;

    localparam logic [ELEM_WIDTH-1:0] ELEM_MOST_NEG = {1'b1, {(ELEM_WIDTH - 1){1'b0}}};
    localparam logic [ELEM_WIDTH-1:0] ELEM_MOST_POS = ~ELEM_MOST_NEG;

    localparam int RANDOM_ITEMS  = 500;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [C_WIDTH-1:0] value;
        logic               flag;
    } t_reply;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CFG_W-1:0]            i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [KIND_W-1:0]           i_req_type;
    logic [POS_W-1:0]            i_row_index;
    logic [POS_W-1:0]            i_col_index;
    logic signed [C_WIDTH-1:0]   i_elem_value;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic [KIND_W-1:0]           o_resp_kind;
    logic signed [C_WIDTH-1:0]   o_read_value;
    logic                        o_sat_flag;

    matrix_multiply_accumulate u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_row_index  (i_row_index),
        .i_col_index  (i_col_index),
        .i_elem_value (i_elem_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_resp_kind  (o_resp_kind),
        .o_read_value (o_read_value),
        .o_sat_flag   (o_sat_flag)
    );

    // shadow copy of the block's storage and size registers
    logic [ELEM_WIDTH-1:0] a_shadow [CELLS];
    logic [ELEM_WIDTH-1:0] b_shadow [CELLS];
    bit                    a_loaded [CELLS];
    bit                    b_loaded [CELLS];
    longint                c_shadow [CELLS];
    bit                    mark_shadow [CELLS];
    logic [CFG_W-1:0]      reg_m, reg_n, reg_k;

    t_reply expected_replies [$];

    int items_sent;
    int runs_sent;
    int sat_runs;
    int reads_sent;
    int dim_settings;
    int replies_seen;
    int mismatches;
    int burst_left;
    bit steady_sender;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d replies outstanding", expected_replies.size());
        $display("matrix_multiply_accumulate: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor

    function automatic int used_dim(input logic [CFG_W-1:0] d);
        return (d > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    function automatic t_reply predict_reply(input logic [KIND_W-1:0] kind,
                                             input logic [POS_W-1:0] row,
                                             input logic [POS_W-1:0] col,
                                             input logic signed [C_WIDTH-1:0] val);
        t_reply r;
        int     slot, mm, nn, kk, ci;
        bit     in_range, any_sat;
        longint prod, sum;
        r.kind   = kind;
        r.value  = '0;
        r.flag   = 1'b0;
        in_range = (row < MAX_DIM) && (col < MAX_DIM);
        slot     = in_range ? int'(row) * MAX_DIM + int'(col) : 0;
        case (kind)
            REQ_WR_A: begin
                if (in_range) begin
                    a_shadow[slot] = val[ELEM_WIDTH-1:0];
                    a_loaded[slot] = 1'b1;
                end
            end
            REQ_WR_B: begin
                if (in_range) begin
                    b_shadow[slot] = val[ELEM_WIDTH-1:0];
                    b_loaded[slot] = 1'b1;
                end
            end
            REQ_WR_C: begin
                if (in_range) begin
                    c_shadow[slot]    = longint'(val);
                    mark_shadow[slot] = 1'b0;
                end
            end
            REQ_RUN: begin
                mm      = used_dim(reg_m);
                nn      = used_dim(reg_n);
                kk      = used_dim(reg_k);
                any_sat = 1'b0;
                // column-outer, inner-dim, row-inner order; clamps feed forward
                for (int j = 0; j < nn; j++) begin
                    for (int l = 0; l < kk; l++) begin
                        for (int i = 0; i < mm; i++) begin
                            ci   = i * MAX_DIM + j;
                            prod = longint'($signed(a_shadow[i * MAX_DIM + l]))
                                 * longint'($signed(b_shadow[l * MAX_DIM + j]));
                            if (ELEM_WIDTH > C_FRAC)
                                prod = prod >>> (ELEM_WIDTH - C_FRAC);
                            else
                                prod = prod <<< (C_FRAC - ELEM_WIDTH);
                            sum = c_shadow[ci] + prod;
                            if (sum > C_MAX) begin
                                sum             = C_MAX;
                                mark_shadow[ci] = 1'b1;
                                any_sat         = 1'b1;
                            end else if (sum < C_MIN) begin
                                sum             = C_MIN;
                                mark_shadow[ci] = 1'b1;
                                any_sat         = 1'b1;
                            end
                            c_shadow[ci] = sum;
                        end
                    end
                end
                r.flag = any_sat;
                if (any_sat)
                    sat_runs++;
            end
            REQ_READ: begin
                if (in_range) begin
                    r.value = C_WIDTH'(c_shadow[slot]);
                    r.flag  = mark_shadow[slot];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // reply checker and receiver stalls

    always @(posedge i_clk) begin
        t_reply got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_resp_kind, o_read_value, o_sat_flag};
            replies_seen++;
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("reply %0d with nothing pending: kind %0d value %h sat %b",
                             replies_seen, got.kind, got.value, got.flag);
            end else begin
                want = expected_replies.pop_front();
                if (got.kind !== want.kind || got.value !== want.value
                        || got.flag !== want.flag) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("reply %0d: want kind %0d value %h sat %b, got kind %0d value %h sat %b",
                                 replies_seen, want.kind, want.value, want.flag,
                                 got.kind, got.value, got.flag);
                end
            end
        end
    end

    initial begin
        logic [15:0] pattern;
        int          phase;
        pattern     = '1;
        phase       = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= pattern[phase];
            phase = (phase + 1) % 16;
            if (phase == 0) begin
                case ($urandom_range(0, 3))
                    0:       pattern = '1;
                    1:       pattern = 16'($urandom);
                    2:       pattern = 16'($urandom | $urandom);
                    default: pattern = 16'($urandom & $urandom);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // request side

    function automatic logic [C_WIDTH-1:0] rand_wide();
        return C_WIDTH'({$urandom, $urandom});
    endfunction

    function automatic logic [C_WIDTH-1:0] rand_elem();
        logic [C_WIDTH-1:0] v;
        v = rand_wide();
        case ($urandom_range(0, 3))
            0:       v[ELEM_WIDTH-1:0] = ELEM_MOST_NEG;
            1:       v[ELEM_WIDTH-1:0] = ELEM_MOST_POS;
            default: ;
        endcase
        return v;
    endfunction

    // C seeds lean toward the rails so runs saturate now and then
    function automatic logic [C_WIDTH-1:0] rand_c();
        case ($urandom_range(0, 3))
            0:       return C_WIDTH'(C_MAX - longint'($urandom_range(0, 32'h4000_0000)));
            1:       return C_WIDTH'(C_MIN + longint'($urandom_range(0, 32'h4000_0000)));
            2:       return C_WIDTH'(longint'($signed($urandom)));
            default: return rand_wide();
        endcase
    endfunction

    function automatic int pick_pos(input int lim);
        return (lim > 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, MAX_DIM - 1);
    endfunction

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        if (r <= 2)
            return $urandom_range(5, 8);
        return $urandom_range(1, 4);
    endfunction

    task automatic pace_sender();
        int gap;
        if (steady_sender)
            return;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic send_req(input logic [KIND_W-1:0] kind, input int row, input int col,
                            input logic [C_WIDTH-1:0] val);
        pace_sender();
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_req_type   <= kind;
        i_row_index  <= POS_W'(row);
        i_col_index  <= POS_W'(col);
        i_elem_value <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_replies.push_back(predict_reply(kind, POS_W'(row), POS_W'(col), $signed(val)));
        items_sent++;
        if (kind == REQ_READ)
            reads_sent++;
    endtask

    // hold the request side until every reply is back
    task automatic drain_all();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(data);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_DIM_M: reg_m = CFG_W'(data);
            CFG_DIM_N: reg_n = CFG_W'(data);
            CFG_DIM_K: reg_k = CFG_W'(data);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_dims(input int m, input int n, input int k);
        drain_all();
        write_reg(CFG_DIM_M, m);
        write_reg(CFG_DIM_N, n);
        write_reg(CFG_DIM_K, k);
        dim_settings++;
    endtask

    // loads any operand the run will touch that was never written, then runs
    task automatic request_run();
        int mm, nn, kk;
        mm = used_dim(reg_m);
        nn = used_dim(reg_n);
        kk = used_dim(reg_k);
        for (int i = 0; i < mm; i++)
            for (int l = 0; l < kk; l++)
                if (!a_loaded[i * MAX_DIM + l])
                    send_req(REQ_WR_A, i, l, rand_elem());
        for (int l = 0; l < kk; l++)
            for (int j = 0; j < nn; j++)
                if (!b_loaded[l * MAX_DIM + j])
                    send_req(REQ_WR_B, l, j, rand_elem());
        send_req(REQ_RUN, pick_pos(0), pick_pos(0), rand_wide());
        runs_sent++;
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 4))
            0: send_req(KIND_W'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI)),
                        pick_pos(0), pick_pos(0), rand_wide());
            1: send_req(REQ_READ, pick_pos(0), pick_pos(0), rand_wide());
            2: send_req(REQ_WR_C, pick_pos(0), pick_pos(0), rand_c());
            3: send_req(REQ_WR_A, pick_pos(0), pick_pos(0), rand_elem());
            default: send_req(REQ_WR_B, pick_pos(0), pick_pos(0), rand_elem());
        endcase
    endtask

    // ------------------------------------------------------------------
    // tests

    task automatic test_reset_state();
        send_req(REQ_READ, 0, 0, '0);
        send_req(REQ_READ, MAX_DIM - 1, MAX_DIM - 1, '1);
        send_req(REQ_READ, 7, 9, rand_wide());
    endtask

    task automatic test_unknown_kinds();
        for (int kind = REQ_RSVD_LO; kind <= REQ_RSVD_HI; kind++)
            send_req(KIND_W'(kind), MAX_DIM - 1, MAX_DIM - 1, '1);
        send_req(REQ_READ, MAX_DIM - 1, MAX_DIM - 1, '0);
    endtask

    task automatic test_saturation();
        set_dims(1, 1, 1);
        send_req(REQ_WR_A, 0, 0, C_WIDTH'(ELEM_MOST_NEG));
        send_req(REQ_WR_B, 0, 0, C_WIDTH'(ELEM_MOST_NEG));
        send_req(REQ_WR_C, 0, 0, C_WIDTH'(C_MAX - 5));
        request_run();                          // clamps high
        send_req(REQ_READ, 0, 0, '0);
        request_run();                          // already at the rail
        send_req(REQ_WR_C, 0, 0, C_WIDTH'(C_MIN + 3));
        send_req(REQ_WR_B, 0, 0, C_WIDTH'(ELEM_MOST_POS));
        request_run();                          // clamps low
        send_req(REQ_WR_B, 0, 0, C_WIDTH'(ELEM_MOST_NEG));
        request_run();                          // no clamp, mark must stay
        send_req(REQ_READ, 0, 0, '0);
        send_req(REQ_WR_C, 0, 0, C_WIDTH'(5));  // write clears the mark
        send_req(REQ_READ, 0, 0, '0);
        send_req(REQ_WR_A, 0, 0, C_WIDTH'(ELEM_MOST_POS));
        send_req(REQ_WR_B, 0, 0, C_WIDTH'(ELEM_MOST_POS));
        request_run();
        send_req(REQ_READ, 0, 0, '0);
        send_req(REQ_WR_C, MAX_DIM - 1, MAX_DIM - 1, C_WIDTH'(C_MIN));
        send_req(REQ_READ, MAX_DIM - 1, MAX_DIM - 1, '0);
    endtask

    task automatic test_zero_dims();
        set_dims(0, 1, 1);
        request_run();
        set_dims(1, 0, 1);
        request_run();
        set_dims(1, 1, 0);
        request_run();
        send_req(REQ_READ, 0, 0, '0);
    endtask

    // one register at a time at its top code, which the block treats as full size
    task automatic test_wide_dims();
        set_dims((1 << CFG_W) - 1, 1, 1);
        request_run();
        send_req(REQ_READ, MAX_DIM - 1, 0, '0);
        set_dims(1, (1 << CFG_W) - 1, 1);
        request_run();
        send_req(REQ_READ, 0, MAX_DIM - 1, '0);
        set_dims(1, 1, (1 << CFG_W) - 1);
        request_run();
        send_req(REQ_READ, 0, 0, '0);
    endtask

    task automatic test_random_traffic();
        int start, mm, nn, kk, reps;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            mm = pick_dim();
            nn = pick_dim();
            kk = pick_dim();
            if ($urandom_range(0, 5) == 0) begin
                mm = $urandom_range(1, 2);
                nn = $urandom_range(1, 2);
                kk = $urandom_range(1, 2);
                case ($urandom_range(0, 2))
                    0:       mm = $urandom_range(MAX_DIM, (1 << CFG_W) - 1);
                    1:       nn = $urandom_range(MAX_DIM, (1 << CFG_W) - 1);
                    default: kk = $urandom_range(MAX_DIM, (1 << CFG_W) - 1);
                endcase
            end
            set_dims(mm, nn, kk);
            steady_sender = ($urandom_range(0, 3) == 0);
            mm   = used_dim(reg_m);
            nn   = used_dim(reg_n);
            kk   = used_dim(reg_k);
            reps = $urandom_range(1, 3);
            repeat (reps) begin
                if (mm * kk + kk * nn <= 40 && $urandom_range(0, 2) != 0) begin
                    for (int i = 0; i < mm; i++)
                        for (int l = 0; l < kk; l++)
                            send_req(REQ_WR_A, i, l, rand_elem());
                    for (int l = 0; l < kk; l++)
                        for (int j = 0; j < nn; j++)
                            send_req(REQ_WR_B, l, j, rand_elem());
                end
                repeat ($urandom_range(0, 3))
                    send_req(REQ_WR_C, pick_pos(mm), pick_pos(nn), rand_c());
                repeat ($urandom_range(0, 2))
                    send_noise();
                request_run();
                if ($urandom_range(0, 4) == 0)
                    drain_all();
                repeat ($urandom_range(1, 6))
                    send_req(REQ_READ, pick_pos(mm), pick_pos(nn), rand_wide());
            end
        end
        steady_sender = 1'b0;
    endtask

    // ------------------------------------------------------------------

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_DIM_M;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_req_type   = REQ_WR_A;
        i_row_index  = '0;
        i_col_index  = '0;
        i_elem_value = '0;
        for (int c = 0; c < CELLS; c++) begin
            a_loaded[c]    = 1'b0;
            b_loaded[c]    = 1'b0;
            c_shadow[c]    = 0;
            mark_shadow[c] = 1'b0;
        end
        reg_m = DIM_RESET;
        reg_n = DIM_RESET;
        reg_k = DIM_RESET;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_unknown_kinds();
        test_saturation();
        test_zero_dims();
        test_wide_dims();
        test_random_traffic();

        drain_all();
        repeat (20) @(posedge i_clk);

        $display("covered %0d requests over %0d size settings: %0d runs (%0d clamped), %0d reads",
                 items_sent, dim_settings, runs_sent, sat_runs, reads_sent);
        $display("replies checked %0d, wrong or unexpected %0d", replies_seen, mismatches);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("matrix_multiply_accumulate: match");
        else
            $display("matrix_multiply_accumulate: mismatch");
        $finish;
    end

endmodule

// File: sim.f
sv/mma_pkg.sv
sv/mma_ab_store.sv
sv/mma_c_store.sv
sv/mma_mac.sv
sv/matrix_multiply_accumulate.sv
dv/tb_matrix_multiply_accumulate.sv
